FILE: rtl/core/ewlr_pkg.sv
// Shared constants, types and address helpers of the waveform table rescaler.
package ewlr_pkg;

	// Table geometry
	localparam int TABLE_COUNT = 5;
	localparam int GROUP_COUNT = 7;
	localparam int PHASE_COUNT = 4;
	localparam int GROUP_BYTES = 7;
	localparam int SLOT_COUNT  = TABLE_COUNT * GROUP_COUNT * PHASE_COUNT;

	// Field and counter widths
	localparam int TBL_W    = 3;
	localparam int BYTE_W   = 6;
	localparam int OFF_W    = 3;
	localparam int SLOT_W   = $clog2(SLOT_COUNT);
	localparam int GRP_W    = $clog2(GROUP_COUNT + 1);
	localparam int PH_W     = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;
	localparam int BGRP_W   = $clog2((2 ** BYTE_W - 1) / GROUP_BYTES + 1);
	localparam int FRAME_W  = 6;
	localparam int FRAME_MAX = 63;
	localparam int TOT_W    = $clog2(GROUP_COUNT * PHASE_COUNT * FRAME_MAX + 1);
	localparam int NET_W    = TOT_W + 1;

	// Frame scaling: (f * speed + ROUND_ADD) / 100 through a reciprocal
	localparam int ROUND_ADD = 50;
	localparam int PROD_W    = 14;
	localparam int DIV_RECIP = 20972;
	localparam int RECIP_W   = 15;
	localparam int DIV_SHIFT = 21;
	localparam int QUOT_W    = 8;

	// Byte index to group: b / 7 as (b * 37) >> 8 over the 6-bit range
	localparam int GRP_RECIP = 37;
	localparam int GRP_SHIFT = 8;
	localparam int GRP_PROD_W = 12;

	localparam logic [7:0] MARK_BYTE   = 8'h01;
	localparam logic [7:0] SPEED_RESET = 8'd60;

	// Operation codes
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_BUILD = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Rail codes
	localparam logic [1:0] RAIL_GND = 2'd0;
	localparam logic [1:0] RAIL_VDH = 2'd1;
	localparam logic [1:0] RAIL_VDL = 2'd2;

	typedef struct packed {
		logic [1:0]        operation;
		logic [TBL_W-1:0]  table_index;
		logic [BYTE_W-1:0] byte_index;
		logic [7:0]        source_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       build_done;
	} rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic             load;
		logic             rd_start;
		logic             emit_rd;
		logic             emit_build;
		logic             build_start;
		logic             tbl_start;
		logic             src_rd;
		logic             blk_acc;
		logic             blk_clr;
		logic             sc_mul;
		logic             sc_div;
		logic             sc_wr;
		logic             gu_set;
		logic [GRP_W-1:0] gu_val;
		logic             bal_clr;
		logic             wrk_rd;
		logic             bal_chk;
		logic             pick_rd;
		logic             bal_wr;
		logic             tbl_commit;
		logic             pad_wr;
		logic             pad_step;
		logic [TBL_W-1:0] tbl;
		logic [GRP_W-1:0] grp;
		logic [PH_W-1:0]  ph;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic             nonblank;
		logic             net_zero;
		logic             found;
		logic [GRP_W-1:0] gu_cur;
		logic             pad_go;
		logic             out_free;
	} sts_t;

	function automatic logic [SLOT_W-1:0] slot_of(input logic [TBL_W-1:0] t,
			input logic [GRP_W-1:0] g, input logic [PH_W-1:0] i);
		logic [SLOT_W-1:0] s;
		s = (SLOT_W'(t) * SLOT_W'(GROUP_COUNT) + SLOT_W'(g)) * SLOT_W'(PHASE_COUNT)
			+ SLOT_W'(i);
		return s;
	endfunction

	function automatic logic [BGRP_W-1:0] grp_of(input logic [BYTE_W-1:0] b);
		logic [GRP_PROD_W-1:0] p;
		p = GRP_PROD_W'(b) * GRP_PROD_W'(GRP_RECIP);
		return p[GRP_SHIFT+BGRP_W-1:GRP_SHIFT];
	endfunction

	function automatic logic [OFF_W-1:0] off_of(input logic [BYTE_W-1:0] b,
			input logic [BGRP_W-1:0] g);
		logic [BYTE_W-1:0] r;
		r = b - BYTE_W'(g) * BYTE_W'(GROUP_BYTES);
		return r[OFF_W-1:0];
	endfunction

endpackage

FILE: rtl/core/ewlr_ctrl.sv
// Sequencing state machine of the waveform table rescaler.
module ewlr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic [1:0]    req_op,
	output logic          req_stall,
	input  ewlr_pkg::sts_t sts,
	output ewlr_pkg::cmd_t cmd
);
	import ewlr_pkg::*;

	localparam logic [4:0] ST_IDLE     = 5'd0;
	localparam logic [4:0] ST_RD_WAIT  = 5'd1;
	localparam logic [4:0] ST_BLK_RD   = 5'd2;
	localparam logic [4:0] ST_BLK_CHK  = 5'd3;
	localparam logic [4:0] ST_SC_RD    = 5'd4;
	localparam logic [4:0] ST_SC_MUL   = 5'd5;
	localparam logic [4:0] ST_SC_DIV   = 5'd6;
	localparam logic [4:0] ST_SC_WR    = 5'd7;
	localparam logic [4:0] ST_BAL_INIT = 5'd8;
	localparam logic [4:0] ST_BAL_RD   = 5'd9;
	localparam logic [4:0] ST_BAL_CHK  = 5'd10;
	localparam logic [4:0] ST_BAL_INC  = 5'd11;
	localparam logic [4:0] ST_BAL_WR   = 5'd12;
	localparam logic [4:0] ST_TBL_END  = 5'd13;
	localparam logic [4:0] ST_PAD_CHK  = 5'd14;
	localparam logic [4:0] ST_PAD_WR   = 5'd15;
	localparam logic [4:0] ST_DONE     = 5'd16;

	logic [4:0]       state_q, state_d;
	logic [TBL_W-1:0] tbl_q, tbl_d;
	logic [GRP_W-1:0] grp_q, grp_d;
	logic [PH_W-1:0]  ph_q, ph_d;
	logic             accept;
	logic             ph_last;
	logic             tbl_last;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign ph_last   = (ph_q == PH_W'(PHASE_COUNT - 1));
	assign tbl_last  = (tbl_q == TBL_W'(TABLE_COUNT - 1));

	// Next state and commands
	always_comb begin
		state_d = state_q;
		tbl_d   = tbl_q;
		grp_d   = grp_q;
		ph_d    = ph_q;
		cmd     = '0;
		cmd.tbl = tbl_q;
		cmd.grp = grp_q;
		cmd.ph  = ph_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_op)
						OP_LOAD: begin
							cmd.load = 1'b1;
						end
						OP_READ: begin
							cmd.rd_start = 1'b1;
							state_d = ST_RD_WAIT;
						end
						OP_BUILD: begin
							cmd.build_start = 1'b1;
							cmd.tbl_start = 1'b1;
							tbl_d = '0;
							grp_d = '0;
							ph_d = '0;
							cmd.tbl = '0;
							state_d = ST_BLK_RD;
						end
						default: begin
						end
					endcase
				end
			end
			ST_RD_WAIT: begin
				if (sts.out_free) begin
					cmd.emit_rd = 1'b1;
					state_d = ST_IDLE;
				end
			end
			// Check whether the group is blank
			ST_BLK_RD: begin
				cmd.src_rd = 1'b1;
				state_d = ST_BLK_CHK;
			end
			ST_BLK_CHK: begin
				if (!ph_last) begin
					cmd.blk_acc = 1'b1;
					ph_d = ph_q + PH_W'(1);
					state_d = ST_BLK_RD;
				end else begin
					cmd.blk_clr = 1'b1;
					ph_d = '0;
					if (sts.nonblank) begin
						state_d = ST_SC_RD;
					end else begin
						cmd.gu_set = 1'b1;
						cmd.gu_val = grp_q;
						state_d = ST_BAL_INIT;
					end
				end
			end
			// Scale one phase
			ST_SC_RD: begin
				cmd.src_rd = 1'b1;
				state_d = ST_SC_MUL;
			end
			ST_SC_MUL: begin
				cmd.sc_mul = 1'b1;
				state_d = ST_SC_DIV;
			end
			ST_SC_DIV: begin
				cmd.sc_div = 1'b1;
				state_d = ST_SC_WR;
			end
			ST_SC_WR: begin
				cmd.sc_wr = 1'b1;
				if (!ph_last) begin
					ph_d = ph_q + PH_W'(1);
					state_d = ST_SC_RD;
				end else begin
					ph_d = '0;
					if (grp_q == GRP_W'(GROUP_COUNT - 1)) begin
						cmd.gu_set = 1'b1;
						cmd.gu_val = grp_q + GRP_W'(1);
						state_d = ST_BAL_INIT;
					end else begin
						grp_d = grp_q + GRP_W'(1);
						state_d = ST_BLK_RD;
					end
				end
			end
			// One rebalance pass: scan, then grow the pick
			ST_BAL_INIT: begin
				if (sts.net_zero || sts.gu_cur == '0) begin
					state_d = ST_TBL_END;
				end else begin
					cmd.bal_clr = 1'b1;
					grp_d = '0;
					ph_d = '0;
					state_d = ST_BAL_RD;
				end
			end
			ST_BAL_RD: begin
				cmd.wrk_rd = 1'b1;
				state_d = ST_BAL_CHK;
			end
			ST_BAL_CHK: begin
				cmd.bal_chk = 1'b1;
				if (ph_last && grp_q == sts.gu_cur - GRP_W'(1)) begin
					state_d = ST_BAL_INC;
				end else begin
					state_d = ST_BAL_RD;
					if (ph_last) begin
						ph_d = '0;
						grp_d = grp_q + GRP_W'(1);
					end else begin
						ph_d = ph_q + PH_W'(1);
					end
				end
			end
			ST_BAL_INC: begin
				if (!sts.found) begin
					state_d = ST_TBL_END;
				end else begin
					cmd.pick_rd = 1'b1;
					state_d = ST_BAL_WR;
				end
			end
			ST_BAL_WR: begin
				cmd.bal_wr = 1'b1;
				state_d = ST_BAL_INIT;
			end
			ST_TBL_END: begin
				cmd.tbl_commit = 1'b1;
				grp_d = '0;
				ph_d = '0;
				if (tbl_last) begin
					tbl_d = '0;
					state_d = ST_PAD_CHK;
				end else begin
					tbl_d = tbl_q + TBL_W'(1);
					state_d = ST_BLK_RD;
				end
			end
			// Pad with ground groups
			ST_PAD_CHK: begin
				if (sts.pad_go) begin
					grp_d = sts.gu_cur;
					ph_d = '0;
					state_d = ST_PAD_WR;
				end else if (tbl_last) begin
					state_d = ST_DONE;
				end else begin
					tbl_d = tbl_q + TBL_W'(1);
				end
			end
			ST_PAD_WR: begin
				cmd.pad_wr = 1'b1;
				if (ph_last) begin
					cmd.pad_step = 1'b1;
					state_d = ST_PAD_CHK;
				end else begin
					ph_d = ph_q + PH_W'(1);
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.emit_build = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// a new table starts with cleared accumulators
		if (state_q == ST_TBL_END && !tbl_last) begin
			cmd.tbl_start = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tbl_q <= '0;
			grp_q <= '0;
			ph_q <= '0;
		end else begin
			state_q <= state_d;
			tbl_q <= tbl_d;
			grp_q <= grp_d;
			ph_q <= ph_d;
		end
	end

endmodule

FILE: rtl/core/ewlr_dpath.sv
// Table memories, frame arithmetic, accumulators and result register.
module ewlr_dpath (
	input  logic           clk,
	input  logic           arst_n,
	input  ewlr_pkg::req_t req,
	input  logic           cfg_valid,
	input  logic [7:0]     cfg_data,
	input  logic           rsp_stall,
	output logic           rsp_valid,
	output ewlr_pkg::rsp_t rsp,
	input  ewlr_pkg::cmd_t cmd,
	output ewlr_pkg::sts_t sts
);
	import ewlr_pkg::*;

	logic [7:0] src_mem [SLOT_COUNT];
	logic [7:0] wrk_mem [SLOT_COUNT];

	logic [7:0]              speed_q;
	logic [GRP_W-1:0]        gu_q [TABLE_COUNT];
	logic [TOT_W-1:0]        tot_q [TABLE_COUNT];
	logic [TOT_W-1:0]        tot_acc_q;
	logic [TOT_W-1:0]        longest_q;
	logic signed [NET_W-1:0] net_q;
	logic [FRAME_W-1:0]      best_q;
	logic [SLOT_W-1:0]       pick_q;
	logic                    found_q;
	logic                    nonblank_q;
	logic [7:0]              src_rd_q;
	logic [7:0]              wrk_rd_q;
	logic [PROD_W-1:0]       p_s1;
	logic [QUOT_W-1:0]       q_s2;
	logic                    rd_ok_q;
	logic [OFF_W-1:0]        rd_off_q;
	logic                    out_valid_q;
	rsp_t                    out_q;

	logic [SLOT_W-1:0]  cur_slot;
	logic [BGRP_W-1:0]  rq_grp;
	logic [OFF_W-1:0]   rq_off;
	logic               rq_tbl_ok;
	logic               rq_phase;
	logic [SLOT_W-1:0]  rq_slot;
	logic               ld_ok;
	logic [GRP_W-1:0]   rd_gu;
	logic               rd_ok;
	logic [1:0]         want_rail;
	logic [FRAME_W-1:0] src_f;
	logic [FRAME_W-1:0] sc_fin;
	logic [TOT_W-1:0]   deficit;
	logic [FRAME_W-1:0] chunk;
	logic               out_free;
	logic               wr_en;
	logic [SLOT_W-1:0]  wr_addr;
	logic [7:0]         wr_data;
	logic               wk_rd_en;
	logic [SLOT_W-1:0]  wk_rd_addr;
	logic [PROD_W+RECIP_W-1:0] quot_full;
	logic [7:0]         rd_byte;

	// Decode the item address
	assign cur_slot  = slot_of(cmd.tbl, cmd.grp, cmd.ph);
	assign rq_grp    = grp_of(req.byte_index);
	assign rq_off    = off_of(req.byte_index, rq_grp);
	assign rq_tbl_ok = int'(req.table_index) < TABLE_COUNT;
	assign rq_phase  = (rq_off != '0) && (int'(rq_off) <= PHASE_COUNT);
	assign rq_slot   = slot_of(req.table_index, GRP_W'(rq_grp), PH_W'(rq_off - OFF_W'(1)));
	assign ld_ok     = rq_tbl_ok && (int'(rq_grp) < GROUP_COUNT) && rq_phase;
	assign rd_gu     = rq_tbl_ok ? gu_q[req.table_index] : '0;
	assign rd_ok     = rq_tbl_ok && (int'(rq_grp) < int'(rd_gu));

	// Scaled frame: raise to one if nonzero, cap at the maximum
	assign src_f  = src_rd_q[FRAME_W-1:0];
	assign quot_full = (PROD_W+RECIP_W)'(p_s1) * (PROD_W+RECIP_W)'(DIV_RECIP);
	always_comb begin
		if (src_f != '0 && q_s2 == '0) begin
			sc_fin = FRAME_W'(1);
		end else if (int'(q_s2) > FRAME_MAX) begin
			sc_fin = FRAME_W'(FRAME_MAX);
		end else begin
			sc_fin = q_s2[FRAME_W-1:0];
		end
	end

	assign want_rail = (!net_q[NET_W-1] && net_q != '0) ? RAIL_VDL : RAIL_VDH;
	assign deficit   = longest_q - tot_q[cmd.tbl];
	assign chunk     = (int'(deficit) > FRAME_MAX) ? FRAME_W'(FRAME_MAX) : deficit[FRAME_W-1:0];
	assign out_free  = !out_valid_q || !rsp_stall;

	// Status back to the controller
	assign sts.nonblank = nonblank_q || (src_rd_q != '0);
	assign sts.net_zero = (net_q == '0);
	assign sts.found    = found_q;
	assign sts.gu_cur   = gu_q[cmd.tbl];
	assign sts.pad_go   = (deficit != '0) && (int'(gu_q[cmd.tbl]) < GROUP_COUNT - 1);
	assign sts.out_free = out_free;

	// Source memory: load write port, sequencer read port
	always_ff @(posedge clk) begin
		if (cmd.load && ld_ok) begin
			src_mem[rq_slot] <= req.source_byte;
		end
		if (cmd.src_rd) begin
			src_rd_q <= src_mem[cur_slot];
		end
	end

	// Work memory port selection
	always_comb begin
		wr_en   = cmd.sc_wr || cmd.pad_wr || cmd.bal_wr;
		wr_addr = cmd.bal_wr ? pick_q : cur_slot;
		if (cmd.bal_wr) begin
			wr_data = {wrk_rd_q[7:6], wrk_rd_q[5:0] + FRAME_W'(1)};
		end else if (cmd.pad_wr) begin
			wr_data = (cmd.ph == '0) ? {RAIL_GND, chunk} : 8'd0;
		end else begin
			wr_data = {src_rd_q[7:6], sc_fin};
		end
		wk_rd_en = cmd.rd_start || cmd.wrk_rd || cmd.pick_rd;
		if (cmd.rd_start) begin
			wk_rd_addr = (rd_ok && rq_phase) ? rq_slot : '0;
		end else if (cmd.pick_rd) begin
			wk_rd_addr = pick_q;
		end else begin
			wk_rd_addr = cur_slot;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			wrk_mem[wr_addr] <= wr_data;
		end
		if (wk_rd_en) begin
			wrk_rd_q <= wrk_mem[wk_rd_addr];
		end
	end

	// Arithmetic and per-table accumulators
	always_ff @(posedge clk) begin
		if (cmd.sc_mul) begin
			p_s1 <= PROD_W'(src_f) * PROD_W'(speed_q) + PROD_W'(ROUND_ADD);
		end
		if (cmd.sc_div) begin
			q_s2 <= quot_full[DIV_SHIFT+QUOT_W-1:DIV_SHIFT];
		end
		if (cmd.build_start) begin
			longest_q <= '0;
		end
		if (cmd.tbl_start) begin
			net_q <= '0;
			tot_acc_q <= '0;
		end
		if (cmd.blk_clr || cmd.build_start) begin
			nonblank_q <= 1'b0;
		end else if (cmd.blk_acc) begin
			nonblank_q <= nonblank_q || (src_rd_q != '0);
		end
		if (cmd.sc_wr) begin
			tot_acc_q <= tot_acc_q + TOT_W'(sc_fin);
			if (src_rd_q[7:6] == RAIL_VDH) begin
				net_q <= net_q + $signed({{(NET_W-FRAME_W){1'b0}}, sc_fin});
			end else if (src_rd_q[7:6] == RAIL_VDL) begin
				net_q <= net_q - $signed({{(NET_W-FRAME_W){1'b0}}, sc_fin});
			end
		end
		if (cmd.bal_clr) begin
			best_q <= '0;
			found_q <= 1'b0;
		end
		if (cmd.bal_chk && wrk_rd_q[7:6] == want_rail && wrk_rd_q[5:0] > best_q
				&& int'(wrk_rd_q[5:0]) < FRAME_MAX) begin
			best_q <= wrk_rd_q[5:0];
			pick_q <= cur_slot;
			found_q <= 1'b1;
		end
		if (cmd.bal_wr) begin
			tot_acc_q <= tot_acc_q + TOT_W'(1);
			net_q <= (want_rail == RAIL_VDH) ? net_q + NET_W'(1) : net_q - NET_W'(1);
		end
		if (cmd.tbl_commit) begin
			tot_q[cmd.tbl] <= tot_acc_q;
			if (tot_acc_q > longest_q) begin
				longest_q <= tot_acc_q;
			end
		end
		if (cmd.pad_step) begin
			tot_q[cmd.tbl] <= tot_q[cmd.tbl] + TOT_W'(chunk);
		end
		if (cmd.rd_start) begin
			rd_ok_q <= rd_ok;
			rd_off_q <= rq_off;
		end
	end

	// Speed register and group counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= SPEED_RESET;
			for (int t = 0; t < TABLE_COUNT; t++) begin
				gu_q[t] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				speed_q <= cfg_data;
			end
			if (cmd.gu_set) begin
				gu_q[cmd.tbl] <= cmd.gu_val;
			end else if (cmd.pad_step) begin
				gu_q[cmd.tbl] <= gu_q[cmd.tbl] + GRP_W'(1);
			end
		end
	end

	// Re-encode a read byte
	always_comb begin
		if (!rd_ok_q) begin
			rd_byte = 8'd0;
		end else if (rd_off_q == OFF_W'(0) || rd_off_q == OFF_W'(5) || rd_off_q == OFF_W'(6)) begin
			rd_byte = MARK_BYTE;
		end else if (int'(rd_off_q) <= PHASE_COUNT) begin
			rd_byte = wrk_rd_q;
		end else begin
			rd_byte = 8'd0;
		end
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_rd || cmd.emit_build) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_rd) begin
			out_q.data_byte <= rd_byte;
			out_q.build_done <= 1'b0;
		end else if (cmd.emit_build) begin
			out_q.data_byte <= 8'd0;
			out_q.build_done <= 1'b1;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

FILE: rtl/core/epaper_waveform_lut_rescaler.sv
// Top level of the e-paper waveform table rescaler.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_t: operation, table, byte, source byte
//  rsp     | out       | rsp_valid/rsp_stall | rsp_t: data_byte, build_done
//  cfg     | in        | cfg_valid/cfg_ready | speed_percent (8 bits)
//
// A load never stalls the input; a read reads the work memory at the accept edge,
// then registers the result once the result register is free.
// A build runs a sequencer over the work memory: a blank check of each group, scaling
// of each decoded group phase by phase, a rebalance that adds one frame per pass,
// then ground pad groups.
// Reset clears the sequencer, group counts and result valid; speed resets to 60.
// req_stall is high for the whole of a read or build; a stalled result holds.
module epaper_waveform_lut_rescaler (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ewlr_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ewlr_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [7:0]     cfg_data
);
	import ewlr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Configuration is always taken
	assign cfg_ready = 1'b1;

	ewlr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req.operation),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ewlr_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

FILE: rtl/core/ewlr_checker.sv
// Port-level checks of the waveform table rescaler, bound to the top level.
module ewlr_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input ewlr_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input ewlr_pkg::rsp_t rsp
);
	import ewlr_pkg::*;

	// A stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// A build acknowledge carries a zero data byte
	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.build_done |-> rsp.data_byte == 8'd0)
		else $error("build acknowledge with nonzero data");

	// A read or build transaction keeps the input stalled next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req.operation == OP_READ || req.operation == OP_BUILD)
		|=> req_stall)
		else $error("input not stalled after read or build");

	// A new result only appears while work is in progress
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result without a pending read or build");

endmodule

bind epaper_waveform_lut_rescaler ewlr_checker u_ewlr_checker (.*);

FILE: tb/tb_top.sv
// Self-checking testbench of the e-paper waveform table rescaler.
`timescale 1ns / 100ps

class lut_scoreboard;
	logic [7:0] src_byte [ewlr_pkg::SLOT_COUNT];
	logic [1:0] rail     [ewlr_pkg::SLOT_COUNT];
	int         frames   [ewlr_pkg::SLOT_COUNT];
	int         gcount   [ewlr_pkg::TABLE_COUNT];
	int         speed;
	int         errors;
	ewlr_pkg::rsp_t expected_q[$];

	function new();
		speed = ewlr_pkg::SPEED_RESET;
		errors = 0;
		foreach (src_byte[s]) begin
			src_byte[s] = '0;
			rail[s] = '0;
			frames[s] = 0;
		end
		foreach (gcount[t]) gcount[t] = 0;
	endfunction

	function int slot(int t, int g, int i);
		return (t * ewlr_pkg::GROUP_COUNT + g) * ewlr_pkg::PHASE_COUNT + i;
	endfunction

	function int net_of(int t);
		int n;
		n = 0;
		for (int g = 0; g < gcount[t]; g++)
			for (int i = 0; i < ewlr_pkg::PHASE_COUNT; i++) begin
				if (rail[slot(t, g, i)] == ewlr_pkg::RAIL_VDH) n += frames[slot(t, g, i)];
				else if (rail[slot(t, g, i)] == ewlr_pkg::RAIL_VDL) n -= frames[slot(t, g, i)];
			end
		return n;
	endfunction

	function int total_of(int t);
		int sum;
		sum = 0;
		for (int g = 0; g < gcount[t]; g++)
			for (int i = 0; i < ewlr_pkg::PHASE_COUNT; i++) sum += frames[slot(t, g, i)];
		return sum;
	endfunction

	// Decode, rebalance charge and pad every table
	function void rebuild_tables();
		int longest, deficit, n, best, pick, g, f, q, chunk;
		logic [1:0] want;
		bit blank, found;
		longest = 0;
		foreach (rail[s]) begin
			rail[s] = '0;
			frames[s] = 0;
		end
		for (int t = 0; t < ewlr_pkg::TABLE_COUNT; t++) begin
			for (g = 0; g < ewlr_pkg::GROUP_COUNT; g++) begin
				blank = 1;
				for (int i = 0; i < ewlr_pkg::PHASE_COUNT; i++)
					if (src_byte[slot(t, g, i)] != 0) blank = 0;
				if (blank) break;
				for (int i = 0; i < ewlr_pkg::PHASE_COUNT; i++) begin
					f = src_byte[slot(t, g, i)][5:0];
					q = (f * speed + ewlr_pkg::ROUND_ADD) / 100;
					if (f != 0 && q == 0) q = 1;
					if (q > ewlr_pkg::FRAME_MAX) q = ewlr_pkg::FRAME_MAX;
					rail[slot(t, g, i)] = src_byte[slot(t, g, i)][7:6];
					frames[slot(t, g, i)] = q;
				end
			end
			gcount[t] = g;
			n = net_of(t);
			while (n != 0) begin
				want = (n > 0) ? ewlr_pkg::RAIL_VDL : ewlr_pkg::RAIL_VDH;
				best = 0;
				pick = 0;
				found = 0;
				for (int gg = 0; gg < gcount[t]; gg++)
					for (int i = 0; i < ewlr_pkg::PHASE_COUNT; i++)
						if (rail[slot(t, gg, i)] == want && frames[slot(t, gg, i)] > best
								&& frames[slot(t, gg, i)] < ewlr_pkg::FRAME_MAX) begin
							best = frames[slot(t, gg, i)];
							pick = slot(t, gg, i);
							found = 1;
						end
				if (!found) break;
				frames[pick]++;
				n = net_of(t);
			end
		end
		for (int t = 0; t < ewlr_pkg::TABLE_COUNT; t++)
			if (total_of(t) > longest) longest = total_of(t);
		for (int t = 0; t < ewlr_pkg::TABLE_COUNT; t++) begin
			deficit = longest - total_of(t);
			while (deficit > 0 && gcount[t] < ewlr_pkg::GROUP_COUNT - 1) begin
				chunk = (deficit > ewlr_pkg::FRAME_MAX) ? ewlr_pkg::FRAME_MAX : deficit;
				rail[slot(t, gcount[t], 0)] = ewlr_pkg::RAIL_GND;
				frames[slot(t, gcount[t], 0)] = chunk;
				gcount[t]++;
				deficit -= chunk;
			end
		end
	endfunction

	function logic [7:0] table_byte(int t, int b);
		int g, off;
		g = b / ewlr_pkg::GROUP_BYTES;
		off = b % ewlr_pkg::GROUP_BYTES;
		if (t >= ewlr_pkg::TABLE_COUNT || g >= gcount[t]) return 8'd0;
		if (off == 0 || off == 5 || off == 6) return ewlr_pkg::MARK_BYTE;
		if (off >= 1 && off <= ewlr_pkg::PHASE_COUNT)
			return {rail[slot(t, g, off - 1)], 6'(frames[slot(t, g, off - 1)])};
		return 8'd0;
	endfunction

	// Note an accepted request and queue its expected response
	function void note_request(ewlr_pkg::req_t r);
		ewlr_pkg::rsp_t e;
		int g, off;
		g = r.byte_index / ewlr_pkg::GROUP_BYTES;
		off = r.byte_index % ewlr_pkg::GROUP_BYTES;
		case (r.operation)
			ewlr_pkg::OP_LOAD: begin
				if (r.table_index < ewlr_pkg::TABLE_COUNT && g < ewlr_pkg::GROUP_COUNT
						&& off >= 1 && off <= ewlr_pkg::PHASE_COUNT)
					src_byte[slot(r.table_index, g, off - 1)] = r.source_byte;
			end
			ewlr_pkg::OP_BUILD: begin
				rebuild_tables();
				e.data_byte = 8'd0;
				e.build_done = 1'b1;
				expected_q.push_back(e);
			end
			ewlr_pkg::OP_READ: begin
				e.data_byte = table_byte(r.table_index, r.byte_index);
				e.build_done = 1'b0;
				expected_q.push_back(e);
			end
			default: ;
		endcase
	endfunction

	function void report(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endfunction

	// Check one accepted response against the oldest expectation
	function void check_response(ewlr_pkg::rsp_t r);
		ewlr_pkg::rsp_t e;
		if (expected_q.size() == 0) begin
			report($sformatf("unexpected response %h/%b", r.data_byte, r.build_done));
			return;
		end
		e = expected_q.pop_front();
		if (r.data_byte !== e.data_byte)
			report($sformatf("data_byte %h, want %h", r.data_byte, e.data_byte));
		if (r.build_done !== e.build_done)
			report($sformatf("build_done %b, want %b", r.build_done, e.build_done));
	endfunction
endclass

module tb_top;
	localparam int CYCLE_LIMIT = 40000000;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_stall;
	ewlr_pkg::req_t req = '0;
	logic           rsp_valid;
	logic           rsp_stall = 1'b0;
	ewlr_pkg::rsp_t rsp;
	logic           cfg_valid = 1'b0;
	logic           cfg_ready;
	logic [7:0]     cfg_data = '0;

	int             send_idle_pct = 0;
	int             recv_stall_pct = 0;
	int             cycles = 0;
	lut_scoreboard  sb = new();

	epaper_waveform_lut_rescaler i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// Stall the response channel at random
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Check each response transaction
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) sb.check_response(rsp);
	end

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Present one request and hold it until accepted
	task automatic send_request(ewlr_pkg::req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
	endtask

	task automatic send_op(logic [1:0] op, int t, int b, int v);
		ewlr_pkg::req_t r;
		r.operation = op;
		r.table_index = t[2:0];
		r.byte_index = b[5:0];
		r.source_byte = v[7:0];
		send_request(r);
	endtask

	// Drain, let trailing loads settle, then write the speed register
	task automatic write_speed(logic [7:0] value);
		req_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.speed = value;
	endtask

	function automatic int pick_phase_byte();
		case ($urandom_range(5))
			0: return 0;
			1: return {2'($urandom_range(3)), 6'h3F};
			2: return {2'($urandom_range(3)), 6'($urandom_range(3))};
			default: return $urandom_range(255);
		endcase
	endfunction

	// Mostly well-formed table loads and reads, some builds, some noise
	task automatic random_traffic(int count);
		int t, g;
		for (int n = 0; n < count; n++) begin
			t = $urandom_range(ewlr_pkg::TABLE_COUNT - 1);
			case ($urandom_range(99)) inside
				[0:54]: begin
					g = $urandom_range(ewlr_pkg::GROUP_COUNT - 1);
					for (int i = 1; i <= ewlr_pkg::PHASE_COUNT; i++)
						send_op(ewlr_pkg::OP_LOAD, t, g * 7 + i, pick_phase_byte());
					n += ewlr_pkg::PHASE_COUNT - 1;
				end
				[55:84]: send_op(ewlr_pkg::OP_READ, t, $urandom_range(48), 0);
				[85:87]: send_op(ewlr_pkg::OP_BUILD, $urandom_range(7), $urandom_range(63),
					$urandom_range(255));
				default: send_op($urandom_range(3), $urandom_range(7), $urandom_range(63),
					$urandom_range(255));
			endcase
		end
	endtask

	initial begin
		int idle_pct[4] = '{0, 82, 0, 37};
		int stall_pct[4] = '{0, 0, 82, 37};
		logic [7:0] speeds[4];
		speeds = '{8'd255, 8'd1, 8'd0, 8'($urandom_range(1, 255))};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Write every source slot so no build sees unloaded bytes
		for (int t = 0; t < ewlr_pkg::TABLE_COUNT; t++)
			for (int g = 0; g < ewlr_pkg::GROUP_COUNT; g++)
				for (int i = 1; i <= ewlr_pkg::PHASE_COUNT; i++)
					send_op(ewlr_pkg::OP_LOAD, t, g * 7 + i, 0);

		// Directed: a read before build, extremes, rails, blank stop, bad addresses
		send_op(ewlr_pkg::OP_READ, 0, 0, 0);
		send_op(ewlr_pkg::OP_LOAD, 0, 1, 8'hFF);
		send_op(ewlr_pkg::OP_LOAD, 0, 2, 8'h41);
		send_op(ewlr_pkg::OP_LOAD, 0, 3, 8'h80);
		send_op(ewlr_pkg::OP_LOAD, 0, 4, 8'h3F);
		send_op(ewlr_pkg::OP_LOAD, 1, 1, 8'h7F);
		send_op(ewlr_pkg::OP_LOAD, 1, 2, 8'h81);
		send_op(ewlr_pkg::OP_LOAD, 2, 1, 8'hBF);
		send_op(ewlr_pkg::OP_LOAD, 0, 0, 8'hAA);
		send_op(ewlr_pkg::OP_LOAD, 7, 1, 8'hAA);
		send_op(ewlr_pkg::OP_LOAD, 0, 63, 8'hAA);
		send_op(2'd3, 0, 1, 8'h55);
		send_op(ewlr_pkg::OP_BUILD, 0, 0, 0);
		for (int b = 0; b < 8; b++) send_op(ewlr_pkg::OP_READ, 0, b, 0);
		send_op(ewlr_pkg::OP_READ, 1, 2, 0);
		send_op(ewlr_pkg::OP_READ, 3, 48, 0);
		send_op(ewlr_pkg::OP_READ, 7, 63, 0);
		send_op(ewlr_pkg::OP_READ, 0, 63, 0);

		// Phases of speed and handshake pressure
		for (int p = 0; p < 4; p++) begin
			write_speed(speeds[p]);
			send_idle_pct = idle_pct[p];
			recv_stall_pct = stall_pct[p];
			random_traffic(225);
			send_op(ewlr_pkg::OP_BUILD, 0, 0, 0);
			for (int b = 0; b < 8; b++) send_op(ewlr_pkg::OP_READ, b % 5, b * 6, 0);
		end

		req_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

FILE: filelist.f
rtl/core/ewlr_pkg.sv
rtl/core/ewlr_ctrl.sv
rtl/core/ewlr_dpath.sv
rtl/core/epaper_waveform_lut_rescaler.sv
rtl/core/ewlr_checker.sv
tb/tb_top.sv
